// ===== rtl/core/text_console_writer_assert.svh =====
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types, command and character codes, row state helpers.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int XW = 8;
  localparam int YW = 7;

  typedef logic [XW-1:0] xpos_t;
  typedef logic [YW-1:0] ypos_t;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_SETC  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_SPACE,
    RS_MEM
  } row_state_e;

  typedef struct packed {
    xpos_t x;
    ypos_t y;
    logic  wr;
    logic  scroll;
  } step_t;

  typedef struct packed {
    logic scroll;
    logic clear;
    logic set_mem;
  } rm_ctrl_t;

  function automatic logic [15:0] row_default(row_state_e st, logic [7:0] attr);
    logic [15:0] v;
    v = 16'h0000;
    if (st == RS_SPACE) begin
      v = {attr, CH_SPACE};
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tcw_step.sv =====
// ----------------------------------------------------------------------------
// Text console writer cursor step
// Next cursor position, write and scroll decision for a put-char.
// ----------------------------------------------------------------------------
module tcw_step import tcw_pkg::*; #(
  parameter int NUM_COLS = 80,
  parameter int NUM_ROWS = 25
) (
  input  xpos_t      x_i,
  input  ypos_t      y_i,
  input  logic [7:0] code_i,
  output step_t      step_o
);

  localparam xpos_t ColsX = xpos_t'(NUM_COLS);
  localparam ypos_t RowsY = ypos_t'(NUM_ROWS);
  localparam ypos_t LastY = ypos_t'(NUM_ROWS - 1);

  xpos_t x1, x2;
  ypos_t y1, y2;
  logic  sc1, sc2, prt;

  always_comb begin
    prt = (code_i >= CH_SPACE);
    x1  = x_i;
    y1  = y_i;
    if (code_i == CH_TAB) begin
      x1 = (x_i + xpos_t'(4)) & ~xpos_t'(3);
    end
    if (code_i == CH_CR) begin
      x1 = '0;
    end
    if (code_i == CH_LF) begin
      x1 = '0;
      y1 = y_i + ypos_t'(1);
    end
    sc1 = (y1 >= RowsY);
    if (sc1) begin
      y1 = LastY;
    end
    x2 = x1;
    if (code_i == CH_BS) begin
      if (x1 != '0) begin
        x2 = x1 - xpos_t'(1);
      end
    end else if (prt) begin
      x2 = x1 + xpos_t'(1);
    end
    y2 = y1;
    if (x2 >= ColsX) begin
      x2 = '0;
      y2 = y1 + ypos_t'(1);
    end
    sc2 = (y2 >= RowsY);
    if (sc2) begin
      y2 = LastY;
    end
    step_o.x      = x2;
    step_o.y      = y2;
    step_o.wr     = prt;
    step_o.scroll = sc1 | sc2;
  end

endmodule

// ===== rtl/core/tcw_rowmap.sv =====
// ----------------------------------------------------------------------------
// Text console writer row map
// Rotating top-row base and per-row content state (zero, spaces, stored).
// ----------------------------------------------------------------------------
module tcw_rowmap import tcw_pkg::*; #(
  parameter int NUM_ROWS = 25,
  parameter int PW       = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rm_ctrl_t      ctrl_i,
  input  logic [PW-1:0] mem_row_i,
  input  logic [PW-1:0] lk_row_i,
  output logic [PW-1:0] lk_phys_o,
  output row_state_e    lk_state_o
);

  localparam logic [PW:0]   RowsP = (PW + 1)'(NUM_ROWS);
  localparam logic [PW-1:0] LastP = PW'(NUM_ROWS - 1);

  logic [PW-1:0] top_q;
  row_state_e    flags_q [NUM_ROWS];
  logic [PW:0]   sum;

  always_comb begin
    sum = {1'b0, top_q} + {1'b0, lk_row_i};
    if (sum >= RowsP) begin
      sum = sum - RowsP;
    end
  end

  assign lk_phys_o  = sum[PW-1:0];
  assign lk_state_o = flags_q[lk_phys_o];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      for (int i = 0; i < NUM_ROWS; i++) begin
        flags_q[i] <= RS_ZERO;
      end
    end else begin
      if (ctrl_i.clear) begin
        top_q <= '0;
        for (int i = 0; i < NUM_ROWS; i++) begin
          flags_q[i] <= (i == NUM_ROWS - 1) ? RS_ZERO : RS_SPACE;
        end
      end else if (ctrl_i.scroll) begin
        top_q          <= (top_q == LastP) ? '0 : top_q + PW'(1);
        flags_q[top_q] <= RS_ZERO;
      end
      if (ctrl_i.set_mem) begin
        flags_q[mem_row_i] <= RS_MEM;
      end
    end
  end

endmodule

// ===== rtl/core/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console: put-char with wrap and scroll, set cursor, clear, read.
// ----------------------------------------------------------------------------
// An item passes from transfer through execute to the hand-off into the output
// register; read-cell from a stored row adds a read state after execute for the
// registered screen RAM read. Scroll and clear only rotate the row base and
// retag rows, so they cost nothing extra. The first character written into a
// row that reset, a scroll or a clear left blank adds a fill state while that
// row is filled in the RAM, one cell a cycle. There is no clearing pass after
// reset. The next item is taken while a result waits.
module text_console_writer import tcw_pkg::*; #(
  parameter int NUM_COLS = 80,
  parameter int NUM_ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  char_code_i,
  input  logic [6:0]  col_i,
  input  logic [4:0]  row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic [15:0] cell_value_o,
  output logic        scrolled_o
);

`include "text_console_writer_assert.svh"

  localparam int PW    = $clog2(NUM_ROWS);
  localparam int CAW   = $clog2(NUM_COLS);
  localparam int AW    = PW + CAW;
  localparam int DEPTH = NUM_ROWS * (2 ** CAW);

  localparam xpos_t          ColsX   = xpos_t'(NUM_COLS);
  localparam xpos_t          LastX   = xpos_t'(NUM_COLS - 1);
  localparam ypos_t          RowsY   = ypos_t'(NUM_ROWS);
  localparam ypos_t          LastY   = ypos_t'(NUM_ROWS - 1);
  localparam logic [CAW-1:0] LastCol = CAW'(NUM_COLS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [1:0]     cmd_q;
  logic [7:0]     code_q;
  logic [6:0]     col_q;
  logic [4:0]     row_q;
  logic [7:0]     attr_q;
  logic [7:0]     clr_attr_q;
  xpos_t          cur_x_q;
  ypos_t          cur_y_q;
  logic [15:0]    res_cell_q;
  logic           res_sc_q;
  logic [PW-1:0]  fill_row_q;
  logic [CAW-1:0] fill_col_q;
  logic [CAW-1:0] wr_col_q;
  logic [15:0]    wr_data_q;
  logic [15:0]    fill_def_q;
  logic           out_valid_q;
  logic [6:0]     out_x_q;
  logic [4:0]     out_y_q;
  logic [15:0]    out_cell_q;
  logic           out_sc_q;

  step_t          step;
  rm_ctrl_t       rm_ctrl;
  logic [PW-1:0]  lk_row;
  logic [PW-1:0]  lk_phys;
  row_state_e     lk_state;
  logic           in_xfer;
  logic           out_free;
  logic           exec_put, exec_read;
  logic           in_rng;
  logic           fill_last;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [15:0]    mem_wdata, mem_rdata;
  xpos_t          set_x;
  ypos_t          set_y;
  logic [15:0]    lk_default;

  tcw_step #(
    .NUM_COLS (NUM_COLS),
    .NUM_ROWS (NUM_ROWS)
  ) u_step (
    .x_i    (cur_x_q),
    .y_i    (cur_y_q),
    .code_i (code_q),
    .step_o (step)
  );

  tcw_rowmap #(
    .NUM_ROWS (NUM_ROWS),
    .PW       (PW)
  ) u_rowmap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (rm_ctrl),
    .mem_row_i  (fill_row_q),
    .lk_row_i   (lk_row),
    .lk_phys_o  (lk_phys),
    .lk_state_o (lk_state)
  );

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign exec_put   = (state_q == S_EXEC) && (cmd_q == CMD_PUT);
  assign exec_read  = (state_q == S_EXEC) && (cmd_q == CMD_READ);
  assign fill_last  = (fill_col_q == LastCol);

  assign in_rng     = (xpos_t'(col_q) < ColsX) && (ypos_t'(row_q) < RowsY);
  assign lk_row     = (cmd_q == CMD_READ) ? PW'(row_q) : PW'(cur_y_q);
  assign lk_default = row_default(lk_state, clr_attr_q);
  assign set_x      = (xpos_t'(col_q) < ColsX) ? xpos_t'(col_q) : LastX;
  assign set_y      = (ypos_t'(row_q) < RowsY) ? ypos_t'(row_q) : LastY;

  always_comb begin
    rm_ctrl.scroll  = exec_put && step.scroll;
    rm_ctrl.clear   = (state_q == S_EXEC) && (cmd_q == CMD_CLEAR);
    rm_ctrl.set_mem = (state_q == S_FILL) && fill_last;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {lk_phys, CAW'(cur_x_q)};
    mem_wdata = {attr_q, code_q};
    if (state_q == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = {fill_row_q, fill_col_q};
      mem_wdata = (fill_col_q == wr_col_q) ? wr_data_q : fill_def_q;
    end else if (exec_put && step.wr && (lk_state == RS_MEM)) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re    = exec_read && in_rng && (lk_state == RS_MEM);
  assign mem_raddr = {lk_phys, CAW'(col_q)};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        if (exec_put && step.wr && (lk_state != RS_MEM)) begin
          state_d = S_FILL;
        end else if (mem_re) begin
          state_d = S_READ;
        end
      end
      S_FILL: begin
        if (fill_last) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      attr_q      <= 8'hFF;
      clr_attr_q  <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      out_valid_q <= 1'b0;
      fill_col_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (state_q == S_EXEC) begin
        case (cmd_q)
          CMD_PUT: begin
            cur_x_q <= step.x;
            cur_y_q <= step.y;
          end
          CMD_SETC: begin
            cur_x_q <= set_x;
            cur_y_q <= set_y;
          end
          CMD_CLEAR: begin
            cur_x_q    <= '0;
            cur_y_q    <= LastY;
            clr_attr_q <= attr_q;
          end
          default: begin
          end
        endcase
      end
      if (state_q == S_FILL) begin
        fill_col_q <= fill_last ? '0 : fill_col_q + CAW'(1);
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= cmd_i;
      code_q <= char_code_i;
      col_q  <= col_i;
      row_q  <= row_i;
    end
    if (state_q == S_EXEC) begin
      res_cell_q <= '0;
      res_sc_q   <= 1'b0;
      fill_row_q <= lk_phys;
      wr_col_q   <= CAW'(cur_x_q);
      wr_data_q  <= {attr_q, code_q};
      fill_def_q <= lk_default;
      case (cmd_q)
        CMD_PUT: begin
          res_sc_q <= step.scroll;
        end
        CMD_CLEAR: begin
          res_sc_q <= 1'b1;
        end
        CMD_READ: begin
          if (in_rng) begin
            res_cell_q <= lk_default;
          end
        end
        default: begin
        end
      endcase
    end
    if (state_q == S_READ) begin
      res_cell_q <= mem_rdata;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_x_q    <= cur_x_q[6:0];
      out_y_q    <= cur_y_q[4:0];
      out_cell_q <= res_cell_q;
      out_sc_q   <= res_sc_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = out_x_q;
  assign cursor_row_o = out_y_q;
  assign cell_value_o = out_cell_q;
  assign scrolled_o   = out_sc_q;

  `TCW_ASSERT(a_cursor_in_range, (cur_x_q < ColsX) && (cur_y_q < RowsY), "cursor off screen")
  `TCW_ASSERT(a_xfer_to_exec, in_xfer |=> (state_q == S_EXEC), "no execute after transfer")
  `TCW_ASSERT(a_ram_we, mem_we |-> (state_q == S_EXEC || state_q == S_FILL), "stray RAM write")
  `TCW_ASSERT(a_scroll_row, (out_valid_q & out_sc_q) |-> (out_y_q == LastY[4:0]), "bad row")
  `TCW_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == S_IDLE && !out_valid_q), "not idle")

endmodule

// ===== tb/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// Text console writer checker
// Watches the command, result and attribute ports. Keeps its own screen,
// cursor and attribute, predicts the result of every accepted command and
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; #(
  parameter int NUM_COLS = 80,
  parameter int NUM_ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  char_code_i,
  input  logic [6:0]  col_i,
  input  logic [4:0]  row_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [6:0]  cursor_col_i,
  input  logic [4:0]  cursor_row_i,
  input  logic [15:0] cell_value_i,
  input  logic        scrolled_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          scrolls_o
);

  localparam int CELLS = NUM_COLS * NUM_ROWS;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [15:0] cell_val;
    logic        scrolled;
  } console_result_t;

  logic [15:0]     screen [CELLS];
  int              cur_x;
  int              cur_y;
  logic [7:0]      attr;
  console_result_t result_q [$];

  function automatic void clear_model();
    int i;
    for (i = 0; i < CELLS; i++) screen[i] = '0;
    cur_x = 0;
    cur_y = 0;
    attr  = 8'hFF;
  endfunction

  function automatic bit scroll_model();
    int i;
    if (cur_y < NUM_ROWS) return 1'b0;
    for (i = 0; i < (NUM_ROWS - 1) * NUM_COLS; i++) screen[i] = screen[i + NUM_COLS];
    for (i = (NUM_ROWS - 1) * NUM_COLS; i < CELLS; i++) screen[i] = '0;
    cur_y = NUM_ROWS - 1;
    return 1'b1;
  endfunction

  function automatic bit put_char_model(input logic [7:0] ch);
    bit sc;
    if (ch == CH_TAB) cur_x = ((cur_x + 4) / 4) * 4;
    if (ch == CH_CR) cur_x = 0;
    if (ch == CH_LF) begin
      cur_x = 0;
      cur_y++;
    end
    sc = scroll_model();
    if (ch == CH_BS) begin
      if (cur_x != 0) cur_x--;
    end else if (ch >= 8'd32) begin
      if (cur_x < NUM_COLS && cur_y < NUM_ROWS) screen[cur_y * NUM_COLS + cur_x] = {attr, ch};
      cur_x++;
    end
    if (cur_x >= NUM_COLS) begin
      cur_x = 0;
      cur_y++;
    end
    if (scroll_model()) sc = 1'b1;
    return sc;
  endfunction

  function automatic console_result_t console_step(input logic [1:0] cmd,
                                                   input logic [7:0] ch,
                                                   input logic [6:0] col,
                                                   input logic [4:0] row);
    console_result_t r;
    int i;
    r = '0;
    case (cmd)
      CMD_PUT: begin
        r.scrolled = put_char_model(ch);
      end
      CMD_SETC: begin
        cur_x = (int'(col) < NUM_COLS) ? int'(col) : NUM_COLS - 1;
        cur_y = (int'(row) < NUM_ROWS) ? int'(row) : NUM_ROWS - 1;
      end
      CMD_CLEAR: begin
        for (i = 0; i < (NUM_ROWS - 1) * NUM_COLS; i++) screen[i] = {attr, CH_SPACE};
        for (i = (NUM_ROWS - 1) * NUM_COLS; i < CELLS; i++) screen[i] = '0;
        cur_x = 0;
        cur_y = NUM_ROWS - 1;
        r.scrolled = 1'b1;
      end
      default: begin
        if (int'(col) < NUM_COLS && int'(row) < NUM_ROWS)
          r.cell_val = screen[int'(row) * NUM_COLS + int'(col)];
      end
    endcase
    r.col = 7'(cur_x);
    r.row = 5'(cur_y);
    return r;
  endfunction

  always @(posedge clk_i) begin
    console_result_t exp_r;
    bit bad;
    if (!rst_ni) begin
      clear_model();
      result_q.delete();
    end else begin
      if (cfg_we_i) attr = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        result_q.push_back(console_step(cmd_i, char_code_i, col_i, row_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count_o++;
        end else begin
          exp_r = result_q.pop_front();
          bad = 1'b0;
          if (cursor_col_i !== exp_r.col) begin
            $error("cursor_col: expected %0d, actual %0d", exp_r.col, cursor_col_i);
            bad = 1'b1;
          end
          if (cursor_row_i !== exp_r.row) begin
            $error("cursor_row: expected %0d, actual %0d", exp_r.row, cursor_row_i);
            bad = 1'b1;
          end
          if (cell_value_i !== exp_r.cell_val) begin
            $error("cell_value: expected %04h, actual %04h", exp_r.cell_val, cell_value_i);
            bad = 1'b1;
          end
          if (scrolled_i !== exp_r.scrolled) begin
            $error("scrolled: expected %0d, actual %0d", exp_r.scrolled, scrolled_i);
            bad = 1'b1;
          end
          if (bad) fail_count_o++;
          if (exp_r.scrolled) scrolls_o++;
          checked_o++;
        end
      end
    end
    pending_o = result_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Text console writer testbench
// Directed commands for the control characters, wrap, scroll, clear and
// out-of-range positions, then phases of random text and cursor traffic, each
// under its own attribute; all but one have random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import tcw_pkg::*;

  localparam int NUM_COLS  = 80;
  localparam int NUM_ROWS  = 25;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 200;
  localparam int LIMIT     = 1000000;
  localparam int SETTLE    = NUM_COLS + 20;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i       = CMD_PUT;
  logic [7:0]  char_code_i = '0;
  logic [6:0]  col_i       = '0;
  logic [4:0]  row_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic [15:0] cell_value_o;
  logic        scrolled_o;

  int fail_count;
  int pending;
  int checked;
  int scrolls;
  int cycles = 0;
  int cmd_count [4] = '{0, 0, 0, 0};
  int attr_writes = 0;
  bit calm = 1'b0;

  text_console_writer #(
    .NUM_COLS(NUM_COLS),
    .NUM_ROWS(NUM_ROWS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .char_code_i (char_code_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .cell_value_o(cell_value_o),
    .scrolled_o  (scrolled_o)
  );

  tcw_checker #(
    .NUM_COLS(NUM_COLS),
    .NUM_ROWS(NUM_ROWS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .cmd_i       (cmd_i),
    .char_code_i (char_code_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .cursor_col_i(cursor_col_o),
    .cursor_row_i(cursor_row_o),
    .cell_value_i(cell_value_o),
    .scrolled_i  (scrolled_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .scrolls_o   (scrolls)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 24);
  end

  // returns after the transfer edge; valid stays up until the next falling edge
  task automatic issue(input logic [1:0] cmd, input logic [7:0] ch,
                       input logic [6:0] col, input logic [4:0] row);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    char_code_i <= ch;
    col_i       <= col;
    row_i       <= row;
    do @(posedge clk_i); while (in_stall_o);
    cmd_count[cmd]++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_attr(input logic [7:0] value);
    @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    attr_writes++;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(126, 32));
    if (r < 80) return 8'($urandom_range(255, 127));
    if (r < 95) begin
      case ($urandom_range(3))
        0: return CH_BS;
        1: return CH_TAB;
        2: return CH_LF;
        default: return CH_CR;
      endcase
    end
    return 8'($urandom_range(31));
  endfunction

  task automatic random_item();
    int r;
    logic [6:0] c;
    logic [4:0] w;
    r = $urandom_range(99);
    if ($urandom_range(99) < 85) begin
      c = 7'($urandom_range(NUM_COLS - 1));
      w = 5'($urandom_range(NUM_ROWS - 1));
    end else begin
      c = 7'($urandom);
      w = 5'($urandom);
    end
    if (r < 60)      issue(CMD_PUT, pick_char(), 7'($urandom), 5'($urandom));
    else if (r < 72) issue(CMD_SETC, 8'($urandom), c, w);
    else if (r < 74) issue(CMD_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
    else             issue(CMD_READ, 8'($urandom), c, w);
  endtask

  initial begin
    int p;
    int i;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset contents and out-of-range read, then the special characters
    issue(CMD_READ, 8'h00, 7'd0, 5'd0);
    issue(CMD_READ, 8'h00, 7'd127, 5'd31);
    issue(CMD_PUT, 8'h41, 7'd0, 5'd0);
    issue(CMD_PUT, 8'hFF, 7'd0, 5'd0);
    issue(CMD_PUT, CH_SPACE, 7'd0, 5'd0);
    issue(CMD_PUT, CH_TAB, 7'd0, 5'd0);
    issue(CMD_PUT, CH_BS, 7'd0, 5'd0);
    issue(CMD_PUT, CH_CR, 7'd0, 5'd0);
    issue(CMD_PUT, CH_BS, 7'd0, 5'd0);
    issue(CMD_PUT, 8'h00, 7'd0, 5'd0);
    issue(CMD_PUT, 8'h1F, 7'd0, 5'd0);
    issue(CMD_PUT, CH_LF, 7'd0, 5'd0);
    // saturating cursor, wrap into scroll, tab into scroll, line feed at bottom
    issue(CMD_SETC, 8'h00, 7'd127, 5'd31);
    issue(CMD_PUT, 8'h7E, 7'd0, 5'd0);
    issue(CMD_SETC, 8'h00, 7'd78, 5'd24);
    issue(CMD_PUT, CH_TAB, 7'd0, 5'd0);
    issue(CMD_PUT, CH_LF, 7'd0, 5'd0);
    issue(CMD_READ, 8'h00, 7'd0, 5'd23);
    drain();
    write_attr(8'h00);
    issue(CMD_CLEAR, 8'h00, 7'd0, 5'd0);
    issue(CMD_READ, 8'h00, 7'd0, 5'd0);
    issue(CMD_READ, 8'h00, 7'd79, 5'd24);
    issue(CMD_SETC, 8'h00, 7'd5, 5'd3);
    issue(CMD_READ, 8'h00, 7'd80, 5'd0);
    issue(CMD_READ, 8'h00, 7'd0, 5'd25);
    issue(CMD_PUT, 8'h5A, 7'd0, 5'd0);

    for (p = 0; p < PHASES; p++) begin
      drain();
      if (p == 0)      write_attr(8'hFF);
      else if (p == 1) write_attr(8'h00);
      else             write_attr(8'($urandom));
      calm = (p == 3);
      for (i = 0; i < PHASE_LEN; i++) random_item();
    end
    drain();
    calm = 1'b0;

    $display("run covered %0d put, %0d set-cursor, %0d clear and %0d read commands",
             cmd_count[CMD_PUT], cmd_count[CMD_SETC], cmd_count[CMD_CLEAR],
             cmd_count[CMD_READ]);
    $display("%0d results compared (%0d with a scroll) over %0d attribute settings",
             checked, scrolls, attr_writes);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
